### sv/postfix_expression_evaluator_assert.svh
// Assertion macros for the postfix expression evaluator.
// Included by the top level; no other dependencies.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PFX_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pfx assertion failed");

// next-cycle implication, disabled during reset
`define PFX_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pfx assertion failed");

`endif

### sv/pfx_pkg.sv
// Shared types and constants for the postfix expression evaluator.
// No dependencies.
package pfx_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int COUNT_WIDTH = $clog2(STACK_DEPTH + 1);
   localparam int CHAR_WIDTH  = 8;
   localparam int STATUS_WIDTH = 3;

   localparam logic [CHAR_WIDTH-1:0] CHAR_PLUS    = 8'h2B;
   localparam logic [CHAR_WIDTH-1:0] CHAR_STAR    = 8'h2A;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NEWLINE = 8'h0A;

   localparam logic [STATUS_WIDTH-1:0] ST_OK    = 3'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_UNDER = 3'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_OVER  = 3'd2;
   localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 3'd3;
   localparam logic [STATUS_WIDTH-1:0] ST_LEFT  = 3'd4;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0]  value;
      logic        [STATUS_WIDTH-1:0] status;
   } result_type;

   typedef struct packed {
      logic                   busy;
      logic [COUNT_WIDTH-1:0] stack_count;
   } core_status_type;

endpackage

### sv/pfx_req_if.sv
// Character channel into the postfix expression evaluator.
// Depends on pfx_pkg.
interface pfx_req_if;
   logic                             valid;
   logic                             ready;
   logic [pfx_pkg::CHAR_WIDTH-1:0]   char_in;

   modport source (output valid, output char_in, input ready);
   modport sink   (input valid, input char_in, output ready);
endinterface

### sv/pfx_rsp_if.sv
// Result channel out of the postfix expression evaluator.
// Depends on pfx_pkg.
interface pfx_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [pfx_pkg::VALUE_WIDTH-1:0] value;
   logic        [pfx_pkg::STATUS_WIDTH-1:0] status;

   modport source (output valid, output value, output status, input ready);
   modport sink   (input valid, input value, input status, output ready);
endinterface

### sv/pfx_core.sv
// Input register, shift-register operand stack and combinational evaluate step.
// Depends on pfx_pkg.
module pfx_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [pfx_pkg::CHAR_WIDTH-1:0]  in_char,
   output logic                            res_push,
   output pfx_pkg::result_type             res_data,
   output pfx_pkg::core_status_type        core_status
);

   localparam int VW = pfx_pkg::VALUE_WIDTH;
   localparam int CW = pfx_pkg::COUNT_WIDTH;
   localparam int SD = pfx_pkg::STACK_DEPTH;

   logic                           valid_ff;
   logic [pfx_pkg::CHAR_WIDTH-1:0] char_ff;
   logic [VW-1:0]                  stack_ff [SD];
   logic [VW-1:0]                  stack_in [SD];
   logic [CW-1:0]                  count_ff, count_in;
   logic [VW-1:0]                  acc_ff, acc_in;
   logic                           building_ff, building_in;
   logic [pfx_pkg::STATUS_WIDTH-1:0] err_ff, err_in, err_num;

   logic          is_digit, is_plus, is_op, is_nl;
   logic          num_end, room, pushed, overflow, op_ok, underflow;
   logic [CW-1:0] count_num;
   logic [VW-1:0] opa, opb, op_result, digit;
   logic [pfx_pkg::STATUS_WIDTH-1:0] status_nl;
   logic [VW-1:0] value_nl;

   always_comb begin
      is_digit  = (char_ff >= pfx_pkg::CHAR_ZERO) && (char_ff <= pfx_pkg::CHAR_NINE);
      is_plus   = (char_ff == pfx_pkg::CHAR_PLUS);
      is_op     = is_plus || (char_ff == pfx_pkg::CHAR_STAR);
      is_nl     = (char_ff == pfx_pkg::CHAR_NEWLINE);
      digit     = VW'(char_ff - pfx_pkg::CHAR_ZERO);
      num_end   = valid_ff && !is_digit && building_ff;
      room      = (count_ff < CW'(SD));
      pushed    = num_end && room;
      overflow  = num_end && !room;
      count_num = pushed ? count_ff + CW'(1) : count_ff;
      op_ok     = valid_ff && is_op && (count_num >= CW'(2));
      underflow = valid_ff && is_op && (count_num < CW'(2));
      opa       = pushed ? acc_ff : stack_ff[0];
      opb       = pushed ? stack_ff[0] : stack_ff[1];
      op_result = is_plus ? (opa + opb) : (opa * opb);
      err_num   = (err_ff != pfx_pkg::ST_OK) ? err_ff :
                  (overflow ? pfx_pkg::ST_OVER : pfx_pkg::ST_OK);
      value_nl  = pushed ? acc_ff : ((count_ff != '0) ? stack_ff[0] : '0);
      if (err_num != pfx_pkg::ST_OK) begin
         status_nl = err_num;
      end else if (count_num == '0) begin
         status_nl = pfx_pkg::ST_EMPTY;
      end else if (count_num > CW'(1)) begin
         status_nl = pfx_pkg::ST_LEFT;
      end else begin
         status_nl = pfx_pkg::ST_OK;
      end
   end

   always_comb begin
      stack_in    = stack_ff;
      count_in    = count_ff;
      acc_in      = acc_ff;
      building_in = building_ff;
      err_in      = err_ff;
      if (valid_ff) begin
         if (is_digit) begin
            acc_in      = VW'({acc_ff, 3'b000}) + VW'({acc_ff, 1'b0}) + digit;
            building_in = 1'b1;
         end else begin
            acc_in      = '0;
            building_in = 1'b0;
            err_in      = (err_num != pfx_pkg::ST_OK) ? err_num :
                          (underflow ? pfx_pkg::ST_UNDER : pfx_pkg::ST_OK);
            if (op_ok) begin
               stack_in[0] = op_result;
               if (!pushed) begin
                  for (int i = 1; i < SD - 1; i++) begin
                     stack_in[i] = stack_ff[i+1];
                  end
                  count_in = count_ff - CW'(1);
               end
            end else if (pushed) begin
               stack_in[0] = acc_ff;
               for (int i = 1; i < SD; i++) begin
                  stack_in[i] = stack_ff[i-1];
               end
               count_in = count_num;
            end
            if (is_nl) begin
               count_in = '0;
               err_in   = pfx_pkg::ST_OK;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         count_ff    <= '0;
         acc_ff      <= '0;
         building_ff <= 1'b0;
         err_ff      <= pfx_pkg::ST_OK;
      end else begin
         valid_ff    <= in_valid;
         count_ff    <= count_in;
         acc_ff      <= acc_in;
         building_ff <= building_in;
         err_ff      <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff  <= in_char;
      stack_ff <= stack_in;
   end

   assign res_push              = valid_ff && is_nl;
   assign res_data.value        = value_nl;
   assign res_data.status       = status_nl;
   assign core_status.busy        = valid_ff;
   assign core_status.stack_count = count_ff;

endmodule

### sv/pfx_rsp_queue.sv
// Two-entry result queue between the evaluate step and the result channel.
// Depends on pfx_pkg.
module pfx_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  pfx_pkg::result_type push_data,
   input  logic                pop,
   output logic [1:0]          count,
   output pfx_pkg::result_type head
);

   pfx_pkg::result_type slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic [1:0]          count_ff, count_in;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      if (pop) begin
         slot0_in = slot1_ff;
         count_in = count_ff - 2'd1;
      end
      if (push) begin
         if (count_in == 2'd0) begin
            slot0_in = push_data;
         end else begin
            slot1_in = push_data;
         end
         count_in = count_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign count = count_ff;
   assign head  = slot0_ff;

endmodule

### sv/postfix_expression_evaluator.sv
// Postfix (RPN) expression evaluator, one character per transaction.
// Depends on pfx_pkg, pfx_req_if, pfx_rsp_if, pfx_core, pfx_rsp_queue and
// postfix_expression_evaluator_assert.svh.
//
// req_ch carries one ASCII character per transaction. Digits build a number,
// any other character ends it and pushes it; '+' and '*' pop two values and
// push the 32-bit wrapping sum or product. A newline ends the expression and
// produces one rsp_ch transaction: the top of the stack and a status code
// (0 ok, 1 underflow, 2 overflow, 3 empty, 4 leftover values).
// Characters other than digits, '+', '*' and newline produce nothing.
// Throughput: one character per cycle unless rsp_ch stalls, as the evaluate step
// on the shift-register stack is combinational. A newline's result passes the
// input register, then the result queue, before it shows on rsp_ch.
// A two-entry result queue lets characters keep flowing while one result
// waits. When rsp_ch stalls, req_ch.ready drops once the queue entries plus
// the character in the input register reach two, unless a result leaves in
// the same cycle.
// Reset clears the stack count, number, error and queue; stack contents are
// never read before being written, so they need no clearing.
module postfix_expression_evaluator (
   input  logic     clock,
   input  logic     reset,
   pfx_req_if.sink   req_ch,
   pfx_rsp_if.source rsp_ch
);

`include "postfix_expression_evaluator_assert.svh"

   localparam logic [pfx_pkg::COUNT_WIDTH-1:0] COUNT_MAX =
      pfx_pkg::COUNT_WIDTH'(pfx_pkg::STACK_DEPTH);

   logic                     req_fire, rsp_fire, res_push;
   logic [1:0]               q_count;
   logic [2:0]               pending;
   pfx_pkg::result_type      res_data, q_head;
   pfx_pkg::core_status_type core_status;

   assign rsp_fire = rsp_ch.valid && rsp_ch.ready;
   assign pending  = 3'(q_count) + 3'(core_status.busy);
   assign req_ch.ready = (pending <= (3'd1 + 3'(rsp_fire)));
   assign req_fire = req_ch.valid && req_ch.ready;

   pfx_core u_core (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_fire),
      .in_char     (req_ch.char_in),
      .res_push    (res_push),
      .res_data    (res_data),
      .core_status (core_status)
   );

   pfx_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .pop       (rsp_fire),
      .count     (q_count),
      .head      (q_head)
   );

   assign rsp_ch.valid  = (q_count != 2'd0);
   assign rsp_ch.value  = q_head.value;
   assign rsp_ch.status = q_head.status;

   `PFX_ASSERT_IMP(a_queue_room, clock, reset, res_push, (q_count != 2'd2) || rsp_fire)
   `PFX_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, core_status.stack_count <= COUNT_MAX)
   `PFX_ASSERT_NXT(a_clear_after_end, clock, reset, res_push, core_status.stack_count == '0)
   `PFX_ASSERT_NXT(a_rsp_after_push, clock, reset, res_push, rsp_ch.valid)

endmodule
